/* src/sorted_key_index_insert_unit_macros.svh */
// Assertion macros used by the checker file.
`ifndef SORTED_KEY_INDEX_INSERT_UNIT_MACROS_SVH
`define SORTED_KEY_INDEX_INSERT_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SKII_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SKII_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* src/skii_pkg.sv */
// ----------------------------------------------------------------------------
// skii_pkg: shared types and constants
// Key layout, status codes and the controller/datapath command structs.
// ----------------------------------------------------------------------------
`default_nettype none
package skii_pkg;
   localparam int unsigned DEPTH = 256;
   localparam int unsigned KEY_BYTES = 50;
   localparam int unsigned KEY_WIDTH = 400;
   localparam int unsigned IDX_WIDTH = $clog2(DEPTH);
   localparam int unsigned CNT_WIDTH = IDX_WIDTH + 1;
   localparam int unsigned LOC_WIDTH = 32;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_PRESENT  = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   // Mask that keeps key bytes below KEY_BYTES; byte 0 is the top byte.
   function automatic logic [KEY_WIDTH-1:0] key_mask();
      logic [KEY_WIDTH-1:0] m;
      m = '0;
      for (int b = 0; b < 50; b++) begin
         if (b < KEY_BYTES) begin
            m[KEY_WIDTH-1-8*b -: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   typedef struct packed {
      logic load;      // capture the request and set the search bounds to the whole table
      logic rd;        // issue a read at probe address
      logic rd_shift;  // issue a read at shift address
      logic cmp;       // compare read data and narrow bounds
      logic chk;       // issue a read at lo for the duplicate check
      logic wr_shift;  // write read data one slot up, step shift address down
      logic wr_new;    // write the new entry at lo
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic lo_in_range;
      logic match;
      logic full;
      logic shift_done;
   } sts_type;
endpackage
`default_nettype wire

/* src/skii_datapath.sv */
// ----------------------------------------------------------------------------
// skii_datapath: entry memory, search bounds and shift pointer
// Holds the sorted key/locator memory and executes controller commands.
// ----------------------------------------------------------------------------
`default_nettype none
module skii_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire skii_pkg::cmd_type                 cmd,
   output skii_pkg::sts_type                      sts,
   input  wire logic [skii_pkg::KEY_WIDTH-1:0]    key_in,
   input  wire logic [skii_pkg::LOC_WIDTH-1:0]    loc_in,
   output logic [skii_pkg::CNT_WIDTH-1:0]         lo_out,
   output logic [skii_pkg::CNT_WIDTH-1:0]         count_out
);
   localparam int unsigned EW = skii_pkg::KEY_WIDTH + skii_pkg::LOC_WIDTH;
   localparam int unsigned CW = skii_pkg::CNT_WIDTH;
   localparam int unsigned IW = skii_pkg::IDX_WIDTH;

   logic [EW-1:0] mem [skii_pkg::DEPTH];
   logic [EW-1:0] rdata_ff;
   logic [skii_pkg::KEY_WIDTH-1:0] key_ff;
   logic [skii_pkg::LOC_WIDTH-1:0] loc_ff;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, ptr_ff, ptr_in, count_ff, count_in;
   logic [CW-1:0] mid, raddr;
   logic [skii_pkg::KEY_WIDTH-1:0] skey;

   assign mid  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign skey = rdata_ff[EW-1 -: skii_pkg::KEY_WIDTH];
   assign raddr = cmd.rd_shift ? (ptr_ff - CW'(1)) : (cmd.rd ? mid : lo_ff);

   always_ff @(posedge clock) begin
      if (cmd.rd || cmd.rd_shift || cmd.chk) begin
         rdata_ff <= mem[raddr[IW-1:0]];
      end
      if (cmd.wr_shift) begin
         mem[ptr_ff[IW-1:0]] <= rdata_ff;
      end else if (cmd.wr_new) begin
         mem[lo_ff[IW-1:0]] <= {key_ff, loc_ff};
      end
      if (cmd.load) begin
         key_ff <= key_in & skii_pkg::key_mask();
         loc_ff <= loc_in;
      end
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      ptr_in = ptr_ff;
      count_in = count_ff;
      if (cmd.load) begin
         lo_in = '0;
         hi_in = count_ff;
         ptr_in = count_ff;
      end else if (cmd.cmp) begin
         if (skey < key_ff) lo_in = mid + CW'(1);
         else hi_in = mid;
      end else if (cmd.wr_shift) begin
         ptr_in = ptr_ff - CW'(1);
      end else if (cmd.wr_new) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         lo_ff <= '0;
         hi_ff <= '0;
         ptr_ff <= '0;
      end else begin
         count_ff <= count_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         ptr_ff <= ptr_in;
      end
   end

   assign sts.search_done = (lo_ff >= hi_ff);
   assign sts.lo_in_range = (lo_ff < count_ff);
   assign sts.match       = (skey == key_ff);
   assign sts.full        = (count_ff >= CW'(skii_pkg::DEPTH));
   assign sts.shift_done  = (ptr_ff <= lo_ff);
   assign lo_out = lo_ff;
   assign count_out = count_ff;
endmodule
`default_nettype wire

/* src/skii_controller.sv */
// ----------------------------------------------------------------------------
// skii_controller: sequencing state machine
// Steps through search, duplicate check, shift and write for one request.
// ----------------------------------------------------------------------------
`default_nettype none
module skii_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output skii_pkg::cmd_type       cmd,
   input  wire skii_pkg::sts_type  sts,
   output skii_pkg::status_type    status_out
);
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_SRCH   = 8'b0000_0010,
      S_CMP    = 8'b0000_0100,
      S_CHKRD  = 8'b0000_1000,
      S_CHK    = 8'b0001_0000,
      S_SHRD   = 8'b0010_0000,
      S_SHWR   = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   skii_pkg::status_type status_ff, status_in;

   always_comb begin
      state_in = state_ff;
      status_in = status_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (sts.search_done) begin
               if (sts.lo_in_range) begin
                  // The equality check needs a registered read at lo.
                  cmd.chk = 1'b1;
                  state_in = S_CHKRD;
               end else if (sts.full) begin
                  status_in = skii_pkg::STATUS_FULL;
                  state_in = S_RESP;
               end else begin
                  state_in = S_SHRD;
               end
            end else begin
               cmd.rd = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.cmp = 1'b1;
            state_in = S_SRCH;
         end
         S_CHKRD: begin
            // The entry at lo is in the read register from here on.
            state_in = S_CHK;
         end
         S_CHK: begin
            if (sts.match) begin
               status_in = skii_pkg::STATUS_PRESENT;
               state_in = S_RESP;
            end else if (sts.full) begin
               status_in = skii_pkg::STATUS_FULL;
               state_in = S_RESP;
            end else begin
               state_in = S_SHRD;
            end
         end
         S_SHRD: begin
            if (sts.shift_done) begin
               cmd.wr_new = 1'b1;
               status_in = skii_pkg::STATUS_INSERTED;
               state_in = S_RESP;
            end else begin
               cmd.rd_shift = 1'b1;
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            cmd.wr_shift = 1'b1;
            state_in = S_SHRD;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         status_ff <= skii_pkg::STATUS_INSERTED;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid = (state_ff == S_RESP);
   assign status_out = status_ff;
endmodule
`default_nettype wire

/* src/sorted_key_index_insert_unit.sv */
// ----------------------------------------------------------------------------
// sorted_key_index_insert_unit: sorted key table with binary-search insert
// Keeps up to 256 keys of 50 bytes in ascending order with a locator each.
// ----------------------------------------------------------------------------
// Usage: a request transaction on req_* carries a 50-byte key and a 32-bit
// record locator. The unit binary-searches the stored table, each probe a
// memory read, then a compare, checks the found slot for a duplicate, and
// for a new key shifts later entries up one slot, a read then a write per
// entry through the single-port entry memory, before writing the new one.
// One response transaction on rsp_* reports status, slot and entry count.
// One request is in flight at a time and req_ready is high only while idle.
// The response holds while rsp_ready is low. Synchronous reset empties the
// table (count zero); memory contents are left undefined and never read
// before they are written.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_key_index_insert_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_key_part0,
   input  wire logic [63:0] req_key_part1,
   input  wire logic [63:0] req_key_part2,
   input  wire logic [63:0] req_key_part3,
   input  wire logic [63:0] req_key_part4,
   input  wire logic [63:0] req_key_part5,
   input  wire logic [15:0] req_key_tail,
   input  wire logic [31:0] req_record_locator,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [8:0]       rsp_slot,
   output logic [8:0]       rsp_entries_after
);
   skii_pkg::cmd_type    cmd;
   skii_pkg::sts_type    sts;
   skii_pkg::status_type status;
   logic [skii_pkg::CNT_WIDTH-1:0] lo, count;

   skii_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .sts(sts), .status_out(status)
   );

   skii_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .key_in({req_key_part0, req_key_part1, req_key_part2, req_key_part3,
               req_key_part4, req_key_part5, req_key_tail}),
      .loc_in(req_record_locator), .lo_out(lo), .count_out(count)
   );

   assign rsp_status = status;
   assign rsp_slot = (status == skii_pkg::STATUS_FULL) ? 9'd0 : 9'(lo);
   assign rsp_entries_after = 9'(count);
endmodule
`default_nettype wire

/* src/skii_checker.sv */
// ----------------------------------------------------------------------------
// skii_checker: port-level assertions
// Watches the top-level ports of the insert unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_key_index_insert_unit_macros.svh"
module skii_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic [8:0] rsp_slot,
   input wire logic [8:0] rsp_entries_after
);
   `SKII_ASSERT_IMP(a_one_in_flight, clock, reset, rsp_valid, !req_ready)
   `SKII_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_status != 2'd3)
   `SKII_ASSERT_IMP(a_count_max, clock, reset, rsp_valid, rsp_entries_after <= 9'd256)
   `SKII_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_slot))
endmodule
bind sorted_key_index_insert_unit skii_checker u_chk (.*);
`default_nettype wire

/* test/tb_sorted_key_index_insert_unit.sv */
// ----------------------------------------------------------------------------
// tb_sorted_key_index_insert_unit: self-checking bench for the sorted key table
// Drives insert requests with random bursts and gaps, stalls the response
// side, predicts status, slot and entry count from its own sorted table copy,
// and compares every response in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_sorted_key_index_insert_unit;
   typedef logic [399:0] key_word_type;

   typedef struct packed {
      skii_pkg::status_type status;
      logic [8:0] slot;
      logic [8:0] entries_after;
   } outcome_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [63:0] req_key_part0, req_key_part1, req_key_part2;
   logic [63:0] req_key_part3, req_key_part4, req_key_part5;
   logic [15:0] req_key_tail;
   logic [31:0] req_record_locator;
   logic rsp_valid;
   logic rsp_ready;
   logic [1:0] rsp_status;
   logic [8:0] rsp_slot;
   logic [8:0] rsp_entries_after;

   // The bench's own copy of the sorted table.
   key_word_type table_keys[$];
   logic [31:0] table_locators[$];
   outcome_type pending_outcomes[$];
   int error_count;
   int burst_left;
   int stall_mode;

   sorted_key_index_insert_unit dut (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // The run ends here if the block stops making progress.
   initial begin
      #200000000;
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Predicts one response and updates the table copy. Bytes beyond KEY_BYTES
   // are dropped before both the search and the store.
   function automatic outcome_type predict_insert(input key_word_type raw_key,
                                                  input logic [31:0] locator);
      key_word_type k;
      int lo, hi, mid, n;
      outcome_type o;
      k = raw_key & skii_pkg::key_mask();
      n = table_keys.size();
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (table_keys[mid] < k) lo = mid + 1;
         else hi = mid;
      end
      if (lo < n && table_keys[lo] == k) begin
         o.status = skii_pkg::STATUS_PRESENT;
         o.slot = lo[8:0];
      end else if (n >= skii_pkg::DEPTH) begin
         o.status = skii_pkg::STATUS_FULL;
         o.slot = '0;
      end else begin
         table_keys.insert(lo, k);
         table_locators.insert(lo, locator);
         o.status = skii_pkg::STATUS_INSERTED;
         o.slot = lo[8:0];
      end
      o.entries_after = 9'(table_keys.size());
      return o;
   endfunction

   // Sends one request transaction; the sender sometimes idles between random bursts.
   task automatic send_key(input key_word_type k, input logic [31:0] locator);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 30)) @(negedge clock);
      end
      burst_left--;
      {req_key_part0, req_key_part1, req_key_part2, req_key_part3,
       req_key_part4, req_key_part5, req_key_tail} = k;
      req_record_locator = locator;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_outcomes.push_back(predict_insert(k, locator));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   function automatic key_word_type random_key();
      key_word_type k;
      for (int i = 0; i < 12; i++) k[i*32 +: 32] = $urandom();
      k[399 -: 16] = 16'($urandom());
      return k;
   endfunction

   // Key built from a small value so that neighbors and duplicates are common.
   function automatic key_word_type clustered_key();
      key_word_type k;
      k = '0;
      k[399 -: 16] = 16'($urandom_range(0, 300));
      if ($urandom_range(0, 3) == 0) k[15:0] = 16'($urandom_range(0, 3));
      return k;
   endfunction

   task automatic drain_responses();
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Restarting a table is not allowed (reset once), so table state carries over.
   task automatic test_extremes();
      key_word_type k;
      send_key('0, 32'h0);
      send_key('1, 32'hFFFF_FFFF);
      send_key('0, 32'h1234_5678);
      send_key('1, 32'h0);
      for (int b = 0; b < 50; b += 7) begin
         k = '0;
         k[399 - 8*b -: 8] = 8'h80;
         send_key(k, $urandom());
      end
      k = '0;
      k[0] = 1'b1;
      send_key(k, $urandom());
      send_key(k, $urandom());
      send_key({$urandom(), 368'h0}, 32'hA5A5_5A5A);
   endtask

   // Clustered keys give duplicates and inserts all over the table.
   task automatic test_clustered(input int count);
      for (int i = 0; i < count; i++) send_key(clustered_key(), $urandom());
   endtask

   // Fills the table, then probes full-table and duplicate-on-full behavior.
   task automatic test_full_table(input int count);
      int n;
      while (table_keys.size() < skii_pkg::DEPTH) send_key(random_key(), $urandom());
      drain_responses();
      for (int i = 0; i < count; i++) begin
         n = table_keys.size();
         if ($urandom_range(0, 1) == 0) send_key(table_keys[$urandom_range(0, n - 1)], $urandom());
         else send_key($urandom_range(0, 1) ? random_key() : clustered_key(), $urandom());
      end
   endtask

   // Checks each response transaction against the oldest prediction.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected response", rsp_slot, 0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status != want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_slot != want.slot) report_mismatch("slot", rsp_slot, want.slot);
            if (rsp_entries_after != want.entries_after)
               report_mismatch("entries_after", rsp_entries_after, want.entries_after);
         end
      end
   end

   // The receiver stalls in phases: always ready, random, or mostly stalled.
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   initial begin
      error_count = 0;
      burst_left = 0;
      stall_mode = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      {req_key_part0, req_key_part1, req_key_part2, req_key_part3,
       req_key_part4, req_key_part5, req_key_tail} = '0;
      req_record_locator = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_extremes();
      drain_responses();
      test_clustered(900);
      test_full_table(650);
      drain_responses();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+src
src/skii_pkg.sv
src/skii_datapath.sv
src/skii_controller.sv
src/sorted_key_index_insert_unit.sv
src/skii_checker.sv
test/tb_sorted_key_index_insert_unit.sv
